### hw/rtl/ghh_pkg.sv
`default_nettype none

package ghh_pkg;

    localparam int SpeedW   = 8;
    localparam int DurW     = 16;
    localparam int GainW    = 24;
    localparam int SmoothW  = 16;
    localparam int FsW      = 24;
    localparam int HeadW    = 32;
    localparam int DriveW   = 10;
    localparam int GyroW    = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int ProdW    = 58;
    localparam int MixW     = 60;
    localparam int GainFrac = 24;
    localparam int SpdShift = 8;

    localparam int DriveMax = 511;

    localparam logic [SpeedW-1:0]  TargetSpeedRst = 8'd0;
    localparam logic [DurW-1:0]    DurationRst    = 16'd10;
    localparam logic [GainW-1:0]   PropGainRst    = 24'd5033;
    localparam logic [GainW-1:0]   DerivGainRst   = 24'd16777;
    localparam logic [SmoothW-1:0] SmoothingRst   = 16'd52429;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TARGET_SPEED = 3'd0,
        REG_DURATION     = 3'd1,
        REG_PROP_GAIN    = 3'd2,
        REG_DERIV_GAIN   = 3'd3,
        REG_SMOOTHING    = 3'd4
    } reg_idx_t;

    // products and speed handed to the drive mixer
    typedef struct packed {
        logic             act;
        logic [FsW-1:0]   fs;
        logic [ProdW-1:0] p_prop;
        logic [ProdW-1:0] p_der;
    } ghh_prod_t;

endpackage

`default_nettype wire

### hw/rtl/ghh_drive_mix.sv
`default_nettype none

module ghh_drive_mix
(
    input  wire ghh_pkg::ghh_prod_t                  prod,
    output logic signed [ghh_pkg::DriveW-1:0]        left_next,
    output logic signed [ghh_pkg::DriveW-1:0]        right_next
);

    logic signed [ghh_pkg::ProdW:0]  corr;
    logic signed [ghh_pkg::MixW-1:0] corr_ext;
    logic signed [ghh_pkg::MixW-1:0] spd;
    logic signed [ghh_pkg::MixW-1:0] left_q24;
    logic signed [ghh_pkg::MixW-1:0] right_q24;

    // Q.24 to integer, truncated toward zero, clipped to +/-511
    function automatic logic signed [ghh_pkg::DriveW-1:0] drive_of
    (
        input logic signed [ghh_pkg::MixW-1:0] v
    );
        logic [ghh_pkg::MixW-1:0]                 mag;
        logic [ghh_pkg::MixW-ghh_pkg::GainFrac-1:0] q;
        logic [ghh_pkg::DriveW-1:0]               qs;
        mag = v[ghh_pkg::MixW-1] ? ghh_pkg::MixW'(-v) : ghh_pkg::MixW'(v);
        q   = mag[ghh_pkg::MixW-1:ghh_pkg::GainFrac];
        if (q > (ghh_pkg::MixW-ghh_pkg::GainFrac)'(ghh_pkg::DriveMax))
            qs = ghh_pkg::DriveW'(ghh_pkg::DriveMax);
        else
            qs = q[ghh_pkg::DriveW-1:0];
        drive_of = v[ghh_pkg::MixW-1] ? $signed(-qs) : $signed(qs);
    endfunction

    always_comb
    begin
        corr      = $signed({prod.p_prop[ghh_pkg::ProdW-1], prod.p_prop})
                  + $signed({prod.p_der[ghh_pkg::ProdW-1], prod.p_der});
        corr_ext  = ghh_pkg::MixW'(corr);
        spd       = $signed({{(ghh_pkg::MixW-ghh_pkg::FsW-ghh_pkg::SpdShift){1'b0}},
                             prod.fs, {ghh_pkg::SpdShift{1'b0}}});
        left_q24  = spd - corr_ext;
        right_q24 = spd + corr_ext;
        if (prod.act)
        begin
            left_next  = drive_of(left_q24);
            right_next = drive_of(right_q24);
        end
        else
        begin
            left_next  = '0;
            right_next = '0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gyro_heading_hold_drive_unit.sv
// Heading-hold drive controller. Each input beat is either a start command
// (clears heading, error history, filtered speed and tick count, and arms a
// run when target_speed and duration_ticks are nonzero) or a 10 ms tick
// carrying a gyro yaw-rate sample. Every input beat yields exactly one output
// beat with left/right drive commands in -511..511 and an active flag; idle
// ticks and start beats give zero drives. One beat is accepted per clock
// while the output is not stalled; beats pass s1, s2, s3 and the output
// register. The heading accumulator and speed filter (a 16x24 and a 17x8
// multiply) update once per beat from s1, which sets the one-beat-per-clock
// rate; the gain products and the drive saturation run in the two following
// stages. Configuration writes are always taken (cfg_ready is tied high)
// and also reach beats in flight; write only while the unit is idle.
`default_nettype none

module gyro_heading_hold_drive_unit
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   start_req,
    input  wire signed [ghh_pkg::GyroW-1:0]       gyro_rate,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic signed [ghh_pkg::DriveW-1:0]     left_drive,
    output logic signed [ghh_pkg::DriveW-1:0]     right_drive,
    output logic                                  active,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [ghh_pkg::CfgIdxW-1:0]            cfg_index,
    input  wire [ghh_pkg::CfgDataW-1:0]           cfg_data
);

    // configuration
    logic [ghh_pkg::SpeedW-1:0]  target_speed_reg;
    logic [ghh_pkg::DurW-1:0]    duration_reg;
    logic [ghh_pkg::GainW-1:0]   prop_gain_reg;
    logic [ghh_pkg::GainW-1:0]   deriv_gain_reg;
    logic [ghh_pkg::SmoothW-1:0] smoothing_reg;

    // controller state
    logic signed [ghh_pkg::HeadW-1:0] heading_reg, heading_next;
    logic signed [ghh_pkg::HeadW-1:0] last_err_reg, last_err_next;
    logic [ghh_pkg::FsW-1:0]          fs_reg, fs_next;
    logic [ghh_pkg::DurW-1:0]         tick_reg, tick_next;
    logic                             running_reg, running_next;

    // pipeline
    logic                             s1_valid_reg;
    logic                             s1_start_reg;
    logic signed [ghh_pkg::GyroW-1:0] s1_gyro_reg;

    logic                             s2_valid_reg;
    logic                             s2_act_reg, s2_act_next;
    logic signed [ghh_pkg::HeadW-1:0] s2_err_reg;
    logic signed [ghh_pkg::HeadW:0]   s2_derr_reg;
    logic [ghh_pkg::FsW-1:0]          s2_fs_reg;

    logic                             s3_valid_reg;
    ghh_pkg::ghh_prod_t               s3_reg, s3_next;

    logic                             out_valid_reg;
    logic signed [ghh_pkg::DriveW-1:0] left_reg, right_reg;
    logic                             active_reg;
    logic signed [ghh_pkg::DriveW-1:0] left_next, right_next;

    logic out_free, s3_free, s2_free, s1_free;

    // tick datapath
    logic signed [ghh_pkg::HeadW:0]     sum_wide;
    logic signed [ghh_pkg::HeadW-1:0]   heading_sat;
    logic signed [ghh_pkg::HeadW-1:0]   err;
    logic signed [ghh_pkg::HeadW:0]     derr;
    logic [ghh_pkg::SmoothW:0]          in_weight;
    logic [ghh_pkg::SmoothW+ghh_pkg::FsW-1:0]    keep_term;
    logic [ghh_pkg::SmoothW+ghh_pkg::SpeedW:0]   add_term;
    logic [ghh_pkg::FsW-1:0]            fs_new;
    logic [ghh_pkg::DurW-1:0]           tick_inc;
    logic signed [ghh_pkg::GainW+ghh_pkg::HeadW:0]   p_prop_full;
    logic signed [ghh_pkg::GainW+ghh_pkg::HeadW+1:0] p_der_full;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;

    always_comb
    begin
        sum_wide = $signed({heading_reg[ghh_pkg::HeadW-1], heading_reg})
                 + (ghh_pkg::HeadW+1)'(s1_gyro_reg);
        if (sum_wide[ghh_pkg::HeadW] != sum_wide[ghh_pkg::HeadW-1])
            heading_sat = sum_wide[ghh_pkg::HeadW]
                        ? $signed({1'b1, {(ghh_pkg::HeadW-1){1'b0}}})
                        : $signed({1'b0, {(ghh_pkg::HeadW-1){1'b1}}});
        else
            heading_sat = sum_wide[ghh_pkg::HeadW-1:0];

        if (heading_sat == $signed({1'b1, {(ghh_pkg::HeadW-1){1'b0}}}))
            err = $signed({1'b0, {(ghh_pkg::HeadW-1){1'b1}}});
        else
            err = -heading_sat;

        derr = $signed({err[ghh_pkg::HeadW-1], err})
             - $signed({last_err_reg[ghh_pkg::HeadW-1], last_err_reg});

        in_weight = (ghh_pkg::SmoothW+1)'(1 << ghh_pkg::SmoothW)
                  - {1'b0, smoothing_reg};
        keep_term = smoothing_reg * fs_reg;
        add_term  = in_weight * target_speed_reg;
        fs_new    = keep_term[ghh_pkg::SmoothW+ghh_pkg::FsW-1:ghh_pkg::SmoothW]
                  + ghh_pkg::FsW'(add_term);

        tick_inc = tick_reg + 1'b1;

        heading_next  = heading_reg;
        last_err_next = last_err_reg;
        fs_next       = fs_reg;
        tick_next     = tick_reg;
        running_next  = running_reg;
        s2_act_next   = 1'b0;
        if (s1_start_reg)
        begin
            heading_next  = '0;
            last_err_next = '0;
            fs_next       = '0;
            tick_next     = '0;
            running_next  = (target_speed_reg != '0) && (duration_reg != '0);
        end
        else if (running_reg)
        begin
            heading_next  = heading_sat;
            last_err_next = err;
            fs_next       = fs_new;
            tick_next     = tick_inc;
            running_next  = !(tick_inc >= duration_reg);
            s2_act_next   = 1'b1;
        end
    end

    always_comb
    begin
        p_prop_full    = $signed({1'b0, prop_gain_reg}) * s2_err_reg;
        p_der_full     = $signed({1'b0, deriv_gain_reg}) * s2_derr_reg;
        s3_next.act    = s2_act_reg;
        s3_next.fs     = s2_fs_reg;
        s3_next.p_prop = ghh_pkg::ProdW'(p_prop_full);
        s3_next.p_der  = ghh_pkg::ProdW'(p_der_full);
    end

    ghh_drive_mix u_mix
    (
        .prod       (s3_reg),
        .left_next  (left_next),
        .right_next (right_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= ghh_pkg::TargetSpeedRst;
            duration_reg     <= ghh_pkg::DurationRst;
            prop_gain_reg    <= ghh_pkg::PropGainRst;
            deriv_gain_reg   <= ghh_pkg::DerivGainRst;
            smoothing_reg    <= ghh_pkg::SmoothingRst;
            heading_reg      <= '0;
            last_err_reg     <= '0;
            fs_reg           <= '0;
            tick_reg         <= '0;
            running_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ghh_pkg::REG_TARGET_SPEED:
                        target_speed_reg <= cfg_data[ghh_pkg::SpeedW-1:0];
                    ghh_pkg::REG_DURATION:
                        duration_reg <= cfg_data[ghh_pkg::DurW-1:0];
                    ghh_pkg::REG_PROP_GAIN:
                        prop_gain_reg <= cfg_data[ghh_pkg::GainW-1:0];
                    ghh_pkg::REG_DERIV_GAIN:
                        deriv_gain_reg <= cfg_data[ghh_pkg::GainW-1:0];
                    ghh_pkg::REG_SMOOTHING:
                        smoothing_reg <= cfg_data[ghh_pkg::SmoothW-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (s1_valid_reg && s2_free)
            begin
                heading_reg  <= heading_next;
                last_err_reg <= last_err_next;
                fs_reg       <= fs_next;
                tick_reg     <= tick_next;
                running_reg  <= running_next;
            end

            if (s1_free)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            s1_start_reg <= start_req;
            s1_gyro_reg  <= gyro_rate;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_act_reg  <= s2_act_next;
            s2_err_reg  <= err;
            s2_derr_reg <= derr;
            s2_fs_reg   <= fs_new;
        end
        if (s2_valid_reg && s3_free)
            s3_reg <= s3_next;
        if (s3_valid_reg && out_free)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            active_reg <= s3_reg.act;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign active      = active_reg;

endmodule

`default_nettype wire

### hw/rtl/ghh_checker.sv
`default_nettype none

module ghh_checker
(
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_stall,
    input wire                                out_valid,
    input wire                                out_stall,
    input wire signed [ghh_pkg::DriveW-1:0]   left_drive,
    input wire signed [ghh_pkg::DriveW-1:0]   right_drive,
    input wire                                active
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_drive)
            && $stable(right_drive) && $stable(active))
        else $error("output beat changed while stalled");

    // inactive beats carry zero drive
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> left_drive == '0 && right_drive == '0)
        else $error("nonzero drive on inactive beat");

    // drives stay within +/-511
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_drive != 10'b10_0000_0000
            && right_drive != 10'b10_0000_0000)
        else $error("drive out of range");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("pipeline not empty in reset");

endmodule

bind gyro_heading_hold_drive_unit ghh_checker u_ghh_checker (.*);

`default_nettype wire

### test/tb_gyro_heading_hold_drive_unit.sv
`timescale 1ns / 1ps

module tb_gyro_heading_hold_drive_unit;

    localparam int      QuietLimit = 2000;
    localparam int      RandomBeats = 1950;
    localparam longint  HeadMax = 64'sd2147483647;
    localparam longint  HeadMin = -64'sd2147483648;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        logic                             start;
        logic signed [ghh_pkg::GyroW-1:0] rate;
    } tick_beat_t;

    typedef struct {
        logic signed [ghh_pkg::DriveW-1:0] left;
        logic signed [ghh_pkg::DriveW-1:0] right;
        logic                              act;
    } drive_beat_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              start_req = 1'b0;
    logic signed [ghh_pkg::GyroW-1:0]  gyro_rate = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [ghh_pkg::DriveW-1:0] left_drive;
    logic signed [ghh_pkg::DriveW-1:0] right_drive;
    logic                              active;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ghh_pkg::CfgIdxW-1:0]       cfg_index = '0;
    logic [ghh_pkg::CfgDataW-1:0]      cfg_data = '0;

    // register mirror
    logic [ghh_pkg::SpeedW-1:0]        set_speed = ghh_pkg::TargetSpeedRst;
    logic [ghh_pkg::DurW-1:0]          set_duration = ghh_pkg::DurationRst;
    logic [ghh_pkg::GainW-1:0]         set_prop = ghh_pkg::PropGainRst;
    logic [ghh_pkg::GainW-1:0]         set_deriv = ghh_pkg::DerivGainRst;
    logic [ghh_pkg::SmoothW-1:0]       set_smooth = ghh_pkg::SmoothingRst;

    // controller state mirror
    logic signed [ghh_pkg::HeadW-1:0]  hold_heading = '0;
    logic signed [ghh_pkg::HeadW-1:0]  hold_prev_err = '0;
    logic [ghh_pkg::FsW-1:0]           hold_speed = '0;
    logic [ghh_pkg::DurW-1:0]          hold_ticks = '0;
    logic                              hold_run = 1'b0;

    tick_beat_t                 pending_beats[$];
    drive_beat_t                expected_drives[$];
    int                         beats_queued = 0;
    int                         beats_accepted = 0;
    int                         mismatches = 0;
    int                         quiet_cycles = 0;
    logic                       in_taken = 1'b0;
    logic                       sender_gaps = 1'b0;
    stall_mode_t                stall_mode = STALL_NONE;

    gyro_heading_hold_drive_unit u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .gyro_rate   (gyro_rate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .active      (active),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic signed [ghh_pkg::HeadW-1:0] clip32(input longint v);
        longint c;
        c = (v > HeadMax) ? HeadMax : ((v < HeadMin) ? HeadMin : v);
        return c[ghh_pkg::HeadW-1:0];
    endfunction

    // Q.24 to integer, truncated toward zero, clamped to +/-DriveMax
    function automatic logic signed [ghh_pkg::DriveW-1:0] drive_of(input longint q24);
        longint mag;
        longint r;
        mag = (q24 < 0) ? -q24 : q24;
        mag = mag >>> ghh_pkg::GainFrac;
        if (mag > ghh_pkg::DriveMax)
        begin
            mag = ghh_pkg::DriveMax;
        end
        r = (q24 < 0) ? -mag : mag;
        return r[ghh_pkg::DriveW-1:0];
    endfunction

    function automatic void heading_step(input logic start,
                                         input logic signed [ghh_pkg::GyroW-1:0] rate,
                                         output drive_beat_t res);
        logic signed [ghh_pkg::HeadW-1:0] err;
        longint                           derr;
        longint                           corr;
        longint                           spd;
        logic [63:0]                      mix;
        res.left = '0;
        res.right = '0;
        res.act = 1'b0;
        if (start)
        begin
            hold_heading = '0;
            hold_prev_err = '0;
            hold_speed = '0;
            hold_ticks = '0;
            hold_run = (set_speed != 0) && (set_duration != 0);
        end
        else if (hold_run)
        begin
            hold_heading = clip32(longint'(hold_heading) + longint'(rate));
            err = clip32(-longint'(hold_heading));
            derr = longint'(err) - longint'(hold_prev_err);
            hold_prev_err = err;
            corr = longint'(set_prop) * longint'(err) + longint'(set_deriv) * derr;
            mix = 64'(set_smooth) * 64'(hold_speed)
                + (64'd65536 - 64'(set_smooth)) * (64'(set_speed) << 16);
            hold_speed = mix[16 +: ghh_pkg::FsW];
            spd = longint'(hold_speed) <<< ghh_pkg::SpdShift;
            res.left = drive_of(spd - corr);
            res.right = drive_of(spd + corr);
            res.act = 1'b1;
            hold_ticks = hold_ticks + 1'b1;
            if (hold_ticks >= set_duration)
            begin
                hold_run = 1'b0;
            end
        end
    endfunction

    function automatic logic signed [ghh_pkg::GyroW-1:0] pick_rate();
        logic [31:0] r;
        int          s;
        r = $urandom;
        s = int'($urandom_range(0, 400)) - 200;
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3, 4: return r[ghh_pkg::GyroW-1:0];
            default: return s[ghh_pkg::GyroW-1:0];
        endcase
    endfunction

    function automatic logic [ghh_pkg::CfgDataW-1:0] pick_gain();
        logic [31:0] r;
        r = $urandom >> $urandom_range(8, 31);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return r[ghh_pkg::GainW-1:0];
        endcase
    endfunction

    // input driver: bursts with random gaps, payload held while stalled
    always @(negedge clk)
    begin : feed
        tick_beat_t b;
        int         burst_left;
        int         gap_left;
        if (burst_left == 0)
        begin
            burst_left = 1;
        end
        if (!in_valid || in_taken)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_beats.size() != 0)
            begin
                b = pending_beats.pop_front();
                in_valid <= 1'b1;
                start_req <= b.start;
                gyro_rate <= b.rate;
                burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = sender_gaps ? $urandom_range(0, 5) : 0;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : backpressure
        int stall_count;
        stall_count = stall_count + 1;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: out_stall <= ((stall_count % 7) < 3);
            default:        out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin : check
        drive_beat_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                heading_step(start_req, gyro_rate, want);
                expected_drives.push_back(want);
                beats_accepted = beats_accepted + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_drives.size() == 0)
                begin
                    $error("unexpected beat: left_drive %0d right_drive %0d active %0b",
                           left_drive, right_drive, active);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (left_drive !== want.left)
                    begin
                        $error("left_drive: expected %0d, got %0d", want.left, left_drive);
                        mismatches = mismatches + 1;
                    end
                    if (right_drive !== want.right)
                    begin
                        $error("right_drive: expected %0d, got %0d", want.right, right_drive);
                        mismatches = mismatches + 1;
                    end
                    if (active !== want.act)
                    begin
                        $error("active: expected %0b, got %0b", want.act, active);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit)
        begin
            $display("tb_gyro_heading_hold_drive_unit NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [ghh_pkg::CfgIdxW-1:0] idx,
                             input logic [ghh_pkg::CfgDataW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ghh_pkg::REG_TARGET_SPEED: set_speed = data[ghh_pkg::SpeedW-1:0];
            ghh_pkg::REG_DURATION:     set_duration = data[ghh_pkg::DurW-1:0];
            ghh_pkg::REG_PROP_GAIN:    set_prop = data[ghh_pkg::GainW-1:0];
            ghh_pkg::REG_DERIV_GAIN:   set_deriv = data[ghh_pkg::GainW-1:0];
            ghh_pkg::REG_SMOOTHING:    set_smooth = data[ghh_pkg::SmoothW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_beat(input logic start,
                              input logic signed [ghh_pkg::GyroW-1:0] rate);
        tick_beat_t b;
        b.start = start;
        b.rate = rate;
        pending_beats.push_back(b);
        beats_queued = beats_queued + 1;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (beats_accepted != beats_queued || expected_drives.size() != 0);
    endtask

    initial
    begin : stimulus
        logic [ghh_pkg::CfgDataW-1:0] v;
        int                           random_goal;
        int                           len;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // writes to unused indexes must not disturb anything
        for (int i = int'(ghh_pkg::REG_SMOOTHING) + 1; i < (1 << ghh_pkg::CfgIdxW); i++)
        begin
            write_reg(i[ghh_pkg::CfgIdxW-1:0], '1);
        end

        // reset config: target zero, no run
        queue_beat(1'b0, 16'sh7fff);
        queue_beat(1'b1, 16'sh8000);
        queue_beat(1'b0, 16'sh8000);
        wait_drained();

        // zero duration, no run
        write_reg(ghh_pkg::REG_TARGET_SPEED, 24'd200);
        write_reg(ghh_pkg::REG_DURATION, 24'd0);
        queue_beat(1'b1, 16'sh0000);
        queue_beat(1'b0, 16'sh0001);
        wait_drained();

        // max gains, no smoothing: drives clamp
        write_reg(ghh_pkg::REG_TARGET_SPEED, 24'd255);
        write_reg(ghh_pkg::REG_DURATION, 24'd6);
        write_reg(ghh_pkg::REG_PROP_GAIN, '1);
        write_reg(ghh_pkg::REG_DERIV_GAIN, '1);
        write_reg(ghh_pkg::REG_SMOOTHING, 24'd0);
        queue_beat(1'b1, 16'sh0000);
        queue_beat(1'b0, 16'sh8000);
        queue_beat(1'b0, 16'sh7fff);
        queue_beat(1'b0, 16'sh0000);
        queue_beat(1'b0, 16'shffff);
        queue_beat(1'b0, 16'sh0001);
        queue_beat(1'b0, 16'sh5555);
        queue_beat(1'b0, 16'sh0000);
        wait_drained();

        // zero gains, maximum retention
        write_reg(ghh_pkg::REG_TARGET_SPEED, 24'd1);
        write_reg(ghh_pkg::REG_DURATION, 24'd3);
        write_reg(ghh_pkg::REG_PROP_GAIN, 24'd0);
        write_reg(ghh_pkg::REG_DERIV_GAIN, 24'd0);
        write_reg(ghh_pkg::REG_SMOOTHING, 24'hffff);
        queue_beat(1'b1, 16'sh1234);
        queue_beat(1'b0, 16'sh8000);
        queue_beat(1'b0, 16'sh7fff);
        queue_beat(1'b0, 16'sh0100);
        queue_beat(1'b0, 16'sh0100);
        wait_drained();

        // restart in the middle of a run
        write_reg(ghh_pkg::REG_TARGET_SPEED, 24'd100);
        write_reg(ghh_pkg::REG_DURATION, 24'hffff);
        write_reg(ghh_pkg::REG_PROP_GAIN, 24'(ghh_pkg::PropGainRst));
        write_reg(ghh_pkg::REG_DERIV_GAIN, 24'(ghh_pkg::DerivGainRst));
        write_reg(ghh_pkg::REG_SMOOTHING, 24'(ghh_pkg::SmoothingRst));
        queue_beat(1'b1, 16'sh0000);
        queue_beat(1'b0, 16'shaaaa);
        queue_beat(1'b1, 16'sh0000);
        queue_beat(1'b0, 16'sh0400);
        queue_beat(1'b0, 16'shfc00);
        wait_drained();

        // target dropped to zero mid-run keeps running
        write_reg(ghh_pkg::REG_TARGET_SPEED, 24'd0);
        queue_beat(1'b0, 16'sh0010);
        queue_beat(1'b0, 16'sh0020);
        wait_drained();

        // duration below tick count ends the run after one more tick
        write_reg(ghh_pkg::REG_DURATION, 24'd1);
        queue_beat(1'b0, 16'sh0030);
        queue_beat(1'b0, 16'sh0040);

        random_goal = beats_queued + RandomBeats;
        while (beats_queued < random_goal)
        begin
            wait_drained();
            sender_gaps = ($urandom_range(0, 3) != 0);
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 9))
                    0: v = 24'd0;
                    1: v = 24'd255;
                    default: v = 24'($urandom_range(1, 255));
                endcase
                write_reg(ghh_pkg::REG_TARGET_SPEED, v);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 19))
                    0: v = 24'd0;
                    1: v = 24'hffff;
                    2: v = 24'd1;
                    default: v = 24'($urandom_range(2, 40));
                endcase
                write_reg(ghh_pkg::REG_DURATION, v);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(ghh_pkg::REG_PROP_GAIN, pick_gain());
            end
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(ghh_pkg::REG_DERIV_GAIN, pick_gain());
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 9))
                    0: v = 24'd0;
                    1: v = 24'hffff;
                    default: v = 24'($urandom_range(0, 65535));
                endcase
                write_reg(ghh_pkg::REG_SMOOTHING, v);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                v = 24'($urandom_range(int'(ghh_pkg::REG_SMOOTHING) + 1,
                                       (1 << ghh_pkg::CfgIdxW) - 1));
                write_reg(v[ghh_pkg::CfgIdxW-1:0], 24'($urandom));
            end
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 6))
                        begin
                            queue_beat(1'($urandom_range(0, 1)), pick_rate());
                        end
                    end
                    1:
                    begin
                        repeat ($urandom_range(1, 8))
                        begin
                            queue_beat(1'b0, pick_rate());
                        end
                    end
                    default:
                    begin
                        if (set_duration == 0 || set_duration > 16'd40)
                        begin
                            len = $urandom_range(1, 40);
                        end
                        else
                        begin
                            len = int'(set_duration) - 1 + int'($urandom_range(0, 3));
                        end
                        queue_beat(1'b1, pick_rate());
                        repeat (len)
                        begin
                            queue_beat(1'b0, pick_rate());
                        end
                    end
                endcase
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_gyro_heading_hold_drive_unit OK");
        end
        else
        begin
            $display("tb_gyro_heading_hold_drive_unit NOT OK");
        end
        $finish;
    end

endmodule
